/* hdl/stir_pkg.sv */
// Package for the sorted table core: beat structs, opcode and status codes,
// cell entry and command types. No dependencies.
package stir_pkg;

  localparam int DEF_TABLE_DEPTH = 8;
  localparam int DEF_KEY_BYTES   = 8;
  localparam int KEY_W           = 64;
  localparam int SAL_W           = 32;
  localparam int IDX_W           = 3;
  localparam int CNT_OUT_W       = 4;

  typedef enum logic [1:0] {
    OP_INS  = 2'd0,
    OP_REM  = 2'd1,
    OP_RD   = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] name_key;
    logic [SAL_W-1:0] salary_cents;
    logic [IDX_W-1:0] read_index;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [KEY_W-1:0]     entry_key;
    logic [SAL_W-1:0]     entry_salary;
    logic [CNT_OUT_W-1:0] entry_count;
  } out_beat_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [SAL_W-1:0] salary;
  } cell_entry_t;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [KEY_W-1:0] key;
    logic [SAL_W-1:0] salary;
  } cell_cmd_t;

endpackage

/* hdl/stir_cell.sv */
// One table slot: holds an entry, compares it with the command key and
// shifts from its left or right neighbor. Depends on stir_pkg.
module stir_cell import stir_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cell_cmd_t   cmd,
  input  cell_entry_t left_ent,
  input  cell_entry_t right_ent,
  input  logic        left_gt,
  input  logic        hit_in,
  output cell_entry_t ent,
  output logic        gt,
  output logic        hit_out
);

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  logic [SAL_W-1:0] sal_r;
  cell_entry_t      ent_nxt;
  logic             eq;

  assign ent     = '{valid: valid_r, key: key_r, salary: sal_r};
  assign gt      = valid_r && (key_r > cmd.key);
  assign eq      = valid_r && (key_r == cmd.key);
  assign hit_out = hit_in | eq;

  always_comb begin
    ent_nxt = ent;
    if (cmd.ins) begin
      if (left_gt) begin
        ent_nxt = left_ent;
      end else if (gt || !valid_r) begin
        // new entry lands in the first slot past the equal keys
        ent_nxt = '{valid: left_ent.valid, key: cmd.key, salary: cmd.salary};
      end
    end else if (cmd.rem && hit_out) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ent_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= ent_nxt.key;
    sal_r <= ent_nxt.salary;
  end

endmodule

/* hdl/sorted_table_insert_remove_core.sv */
// Sorted table core: a row of TABLE_DEPTH stir_cell slots kept in key order.
// The result strobe is registered, high in the cycle after the accepting edge;
// one beat per cycle, busy is never raised. Insert and remove settle in the
// cell row at the accepting edge through its compare and first-match chains.
// Reset (rst_n low, synchronous) empties the table; slot data is not cleared.
// Depends on stir_pkg and stir_cell.
module sorted_table_insert_remove_core import stir_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_data,
  output logic      out_valid,
  output out_beat_t out_data
);

  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int RD_SPAN = (TABLE_DEPTH < (1 << IDX_W)) ? TABLE_DEPTH : (1 << IDX_W);
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  out_beat_t        out_r, out_nxt;
  logic             accept;
  logic             full, empty, found, rd_ok;
  logic [KEY_W-1:0] key_m;
  cell_cmd_t        cmd;
  cell_entry_t      ents [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] gts, hits, valids;
  cell_entry_t      rd_ent;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign key_m  = in_data.name_key & KEY_MASK;
  assign full   = (count_r == CNT_W'(TABLE_DEPTH));
  assign empty  = (count_r == '0);
  assign found  = hits[TABLE_DEPTH-1];
  assign rd_ok  = (CMP_W'(in_data.read_index) < CMP_W'(count_r));

  assign cmd.ins    = accept && (in_data.opcode == OP_INS) && !full;
  assign cmd.rem    = accept && (in_data.opcode == OP_REM) && !empty;
  assign cmd.key    = key_m;
  assign cmd.salary = in_data.salary_cents;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cell_entry_t l_ent, r_ent;
    logic        l_gt, h_in;
    if (i == 0) begin : g_first
      assign l_ent = '{valid: 1'b1, key: '0, salary: '0};
      assign l_gt  = 1'b0;
      assign h_in  = 1'b0;
    end else begin : g_mid
      assign l_ent = ents[i-1];
      assign l_gt  = gts[i-1];
      assign h_in  = hits[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign r_ent = '{valid: 1'b0, key: '0, salary: '0};
    end else begin : g_inner
      assign r_ent = ents[i+1];
    end
    stir_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_ent  (l_ent),
      .right_ent (r_ent),
      .left_gt   (l_gt),
      .hit_in    (h_in),
      .ent       (ents[i]),
      .gt        (gts[i]),
      .hit_out   (hits[i])
    );
    assign valids[i] = ents[i].valid;
  end

  always_comb begin
    rd_ent = '{valid: 1'b0, key: '0, salary: '0};
    for (int i = 0; i < RD_SPAN; i++) begin
      if (in_data.read_index == IDX_W'(i)) begin
        rd_ent = ents[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    out_nxt   = '0;
    case (in_data.opcode)
      OP_INS: begin
        if (full) begin
          out_nxt.status = ST_FULL;
        end else begin
          out_nxt.status = ST_OK;
          count_nxt      = count_r + 1'b1;
        end
      end
      OP_REM: begin
        if (empty) begin
          out_nxt.status = ST_EMPTY;
        end else if (!found) begin
          out_nxt.status = ST_NOT_FOUND;
        end else begin
          out_nxt.status = ST_OK;
          count_nxt      = count_r - 1'b1;
        end
      end
      OP_RD: begin
        if (rd_ok) begin
          out_nxt.status       = ST_OK;
          out_nxt.entry_key    = rd_ent.key;
          out_nxt.entry_salary = rd_ent.salary;
        end else begin
          out_nxt.status = ST_BAD_INDEX;
        end
      end
      default: begin
        out_nxt.status = ST_OK;
      end
    endcase
    out_nxt.entry_count = CNT_OUT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valids) == int'(count_r))
    else $error("slot valid bits disagree with fill count");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.opcode == OP_INS && !full) |=> (count_r == $past(count_r) + 1'b1))
    else $error("accepted insert did not grow the table");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |->
      (out_data.entry_key == '0 && out_data.entry_salary == '0))
    else $error("refused beat carries entry data");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && TABLE_DEPTH > 1 && ents[1].valid) |-> (ents[0].key <= ents[1].key))
    else $error("head of table out of order");
`endif

endmodule

/* sim/tb_top.sv */
// Self-checking bench for sorted_table_insert_remove_core: a table tracker
// predicts each reply, tasks drive bursts of directed and random commands.
// Depends on stir_pkg and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import stir_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * DEF_KEY_BYTES);
  localparam int RANDOM_ITEMS = 1650;
  localparam int CYCLE_LIMIT = 200000;

  class sorted_table_tracker;
    logic [KEY_W-1:0] key_slots[DEPTH];
    logic [SAL_W-1:0] salary_slots[DEPTH];
    int fill;
    out_beat_t pending_replies[$];
    int mismatches;
    int status_tally[5];
    int accepted;

    function new();
      fill = 0;
      mismatches = 0;
      accepted = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function void apply_command(in_beat_t b);
      out_beat_t r;
      logic [KEY_W-1:0] k;
      int pos;
      r = '0;
      k = b.name_key & KEY_MASK;
      accepted++;
      case (b.opcode)
        OP_INS: begin
          if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            pos = fill;
            while (pos > 0 && key_slots[pos-1] > k) begin
              key_slots[pos] = key_slots[pos-1];
              salary_slots[pos] = salary_slots[pos-1];
              pos--;
            end
            key_slots[pos] = k;
            salary_slots[pos] = b.salary_cents;
            fill++;
          end
        end
        OP_REM: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            pos = 0;
            while (pos < fill && key_slots[pos] != k) pos++;
            if (pos >= fill) begin
              r.status = ST_NOT_FOUND;
            end else begin
              for (int i = pos; i + 1 < fill; i++) begin
                key_slots[i] = key_slots[i+1];
                salary_slots[i] = salary_slots[i+1];
              end
              fill--;
            end
          end
        end
        OP_RD: begin
          if (b.read_index < fill) begin
            r.entry_key = key_slots[b.read_index];
            r.entry_salary = salary_slots[b.read_index];
          end else begin
            r.status = ST_BAD_INDEX;
          end
        end
        default: ;
      endcase
      r.entry_count = CNT_OUT_W'(fill);
      status_tally[r.status]++;
      pending_replies.push_back(r);
    endfunction

    function void check_reply(out_beat_t got);
      out_beat_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.entry_key !== want.entry_key) begin
        $display("%0t: entry_key expected %h got %h", $time, want.entry_key, got.entry_key);
        mismatches++;
      end
      if (got.entry_salary !== want.entry_salary) begin
        $display("%0t: entry_salary expected %h got %h", $time, want.entry_salary,
                 got.entry_salary);
        mismatches++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count expected %0d got %0d", $time, want.entry_count,
                 got.entry_count);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_data;
  logic      out_valid;
  out_beat_t out_data;

  sorted_table_tracker tracker = new();
  logic [KEY_W-1:0] key_pool[16];
  int cycle_count = 0;

  sorted_table_insert_remove_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // reply first: it belongs to the beat taken at the previous edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) tracker.check_reply(out_data);
      if (start && !busy) tracker.apply_command(in_data);
    end
  end

  function automatic in_beat_t mk(opcode_t op, logic [KEY_W-1:0] k, logic [SAL_W-1:0] s,
                                  logic [IDX_W-1:0] idx);
    in_beat_t b;
    b.opcode = op;
    b.name_key = k;
    b.salary_cents = s;
    b.read_index = idx;
    return b;
  endfunction

  function automatic logic [KEY_W-1:0] name_like_key();
    logic [KEY_W-1:0] k;
    int len;
    k = '0;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++)
      k[KEY_W-1-8*i -: 8] = 8'h61 + 8'($urandom_range(0, 2));
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return key_pool[$urandom_range(0, 15)];
    if (sel < 80) return {$urandom, $urandom};
    return name_like_key();
  endfunction

  function automatic in_beat_t random_item(int phase);
    in_beat_t b;
    int r;
    int ins_lim;
    int rem_lim;
    ins_lim = (phase == 0) ? 55 : (phase == 1) ? 15 : 35;
    rem_lim = (phase == 2) ? 65 : 70;
    r = $urandom_range(0, 99);
    b.opcode = (r < ins_lim) ? OP_INS : (r < rem_lim) ? OP_REM : (r < 96) ? OP_RD : OP_NOP;
    b.name_key = pick_key();
    if (b.opcode == OP_REM && tracker.fill > 0 && $urandom_range(0, 1))
      b.name_key = tracker.key_slots[$urandom_range(0, tracker.fill - 1)];
    r = $urandom_range(0, 9);
    b.salary_cents = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
    b.read_index = IDX_W'($urandom_range(0, 7));
    return b;
  endfunction

  task automatic send_item(input in_beat_t b);
    start <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    int sent;
    int burst;
    int phase;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    for (int i = 0; i < 16; i++)
      key_pool[i] = (i < 8) ? {$urandom, $urandom} : name_like_key();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_item(mk(OP_RD, '0, '0, 3'd0));
    send_item(mk(OP_REM, 64'd5, '0, '0));
    send_item(mk(OP_NOP, '1, '1, '1));
    send_item(mk(OP_INS, '1, '1, '0));
    send_item(mk(OP_INS, '0, '0, '1));
    send_item(mk(OP_INS, {"bob", 40'd0}, 32'd1, '0));
    send_item(mk(OP_INS, {"bob", 40'd0}, 32'd2, '0));
    idle_cycles(2);
    send_item(mk(OP_INS, {"bob", 40'd0}, 32'd3, '0));
    send_item(mk(OP_REM, {"alice", 24'd0}, '0, '0));
    send_item(mk(OP_INS, {"alice", 24'd0}, 32'd12345, '0));
    send_item(mk(OP_INS, {"bobby", 24'd0}, 32'd99, '0));
    send_item(mk(OP_INS, {"carl", 32'd0}, 32'hDEADBEEF, '0));
    send_item(mk(OP_INS, {"dave", 32'd0}, 32'd7, '0));
    for (int i = 0; i < DEPTH; i++) send_item(mk(OP_RD, '0, '0, IDX_W'(i)));
    send_item(mk(OP_REM, {"bob", 40'd0}, '0, '0));
    send_item(mk(OP_RD, '0, '0, 3'd7));
    send_item(mk(OP_RD, '0, '0, 3'd2));
    idle_cycles(1);

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) phase = $urandom_range(0, 2);
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        in_beat_t b;
        if ($urandom_range(0, 49) == 0) key_pool[$urandom_range(2, 15)] = pick_key();
        b = random_item(phase);
        send_item(b);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 5));
    end
    idle_cycles(1);

    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d commands: %0d ok, %0d full, %0d empty", tracker.accepted,
             tracker.status_tally[ST_OK], tracker.status_tally[ST_FULL],
             tracker.status_tally[ST_EMPTY]);
    $display("  %0d remove misses, %0d reads past count, %0d mismatches",
             tracker.status_tally[ST_NOT_FOUND], tracker.status_tally[ST_BAD_INDEX],
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
